// ----- hw/rtl/czs_pkg.sv -----
// Shared constants, codes and types for the column z-score standardizer.
// Used by the sample store, the shared arithmetic unit and the top level.
// Depends on nothing.
package czs_pkg;

    // Table bounds.
    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLS    = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    // Widths that follow from the bounds.
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int CFG_W    = 4;
    localparam int COL_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int S1_W     = SAMPLE_BITS + ROWS_W;
    localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
    localparam int S2_W     = SQ_W + ROWS_W - 1;
    localparam int MEAN_W   = SAMPLE_BITS + FRAC_W + 1;
    localparam int DIFF_W   = MEAN_W + 1;
    localparam int SPREAD_W = 50;
    localparam int ARITH_W  = 100;
    localparam int ITER_W   = $clog2(ARITH_W + 1);
    localparam int TUSER_W  = 5;

    // Input command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROWS,
        ST_COL,
        ST_RD,
        ST_SQ,
        ST_ACC,
        ST_STAT,
        ST_MULA,
        ST_MULB,
        ST_SQRT,
        ST_SPRD,
        ST_MEAN,
        ST_RX,
        ST_RDIV,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/czs_store.sv -----
// Sample store: one write port and one registered read port.
// Depends on czs_pkg for the depth and sample width.
module czs_store (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [czs_pkg::ADDR_W-1:0]          waddr,
    input  logic [czs_pkg::SAMPLE_BITS-1:0]     wdata,
    input  logic [czs_pkg::ADDR_W-1:0]          raddr,
    output logic [czs_pkg::SAMPLE_BITS-1:0]     rdata
);
    import czs_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/czs_arith.sv -----
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide
// and integer square root, one step per cycle through one wide adder.
// Depends on czs_pkg for widths and operation codes.
module czs_arith (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  czs_pkg::arith_req_t           req,
    input  logic [czs_pkg::ARITH_W-1:0]   opa,
    input  logic [czs_pkg::ARITH_W-1:0]   opb,
    output logic                          done,
    output logic [czs_pkg::ARITH_W-1:0]   result,
    output logic [czs_pkg::ARITH_W-1:0]   remainder
);
    import czs_pkg::*;

    localparam logic [ARITH_W-1:0] SQRT_BIT = ARITH_W'(1) << (ARITH_W - 2);

    arith_op_t          op_reg, op_next;
    logic [ARITH_W-1:0] x_reg, x_next;
    logic [ARITH_W-1:0] y_reg, y_next;
    logic [ARITH_W-1:0] acc_reg, acc_next;
    logic [ARITH_W-1:0] q_reg, q_next;
    logic [ITER_W-1:0]  cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    logic [ARITH_W-1:0] shifted_rem;
    logic [ARITH_W-1:0] add_a, add_b;
    logic               sub;
    logic [ARITH_W:0]   sum;
    logic               finished;

    // Operand selection for the one shared adder.
    always_comb begin
        shifted_rem = {acc_reg[ARITH_W-2:0], x_reg[ARITH_W-1]};
        unique case (op_reg)
            OP_MUL: begin
                add_a = acc_reg;
                add_b = x_reg;
                sub   = 1'b0;
            end
            OP_DIV: begin
                add_a = shifted_rem;
                add_b = y_reg;
                sub   = 1'b1;
            end
            OP_SQRT: begin
                add_a = x_reg;
                add_b = acc_reg | y_reg;
                sub   = 1'b1;
            end
            default: begin
                add_a = acc_reg;
                add_b = x_reg;
                sub   = 1'b0;
            end
        endcase
        sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + (ARITH_W + 1)'(sub);
        finished = (op_reg == OP_DIV) ? (cnt_reg == ITER_W'(ARITH_W)) : (y_reg == '0);
    end

    // One iteration per cycle; the carry out of a subtract is the compare.
    always_comb begin
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start) begin
            op_next  = req.op;
            x_next   = opa;
            y_next   = (req.op == OP_SQRT) ? SQRT_BIT : opb;
            acc_next = '0;
            q_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (finished) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                unique case (op_reg)
                    OP_MUL: begin
                        if (y_reg[0]) begin
                            acc_next = sum[ARITH_W-1:0];
                        end
                        x_next = x_reg << 1;
                        y_next = y_reg >> 1;
                    end
                    OP_DIV: begin
                        acc_next = sum[ARITH_W] ? sum[ARITH_W-1:0] : shifted_rem;
                        q_next   = {q_reg[ARITH_W-2:0], sum[ARITH_W]};
                        x_next   = x_reg << 1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    OP_SQRT: begin
                        if (sum[ARITH_W]) begin
                            x_next   = sum[ARITH_W-1:0];
                            acc_next = (acc_reg >> 1) | y_reg;
                        end else begin
                            acc_next = acc_reg >> 1;
                        end
                        y_next = y_reg >> 2;
                    end
                    default: begin
                        run_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign result    = (op_reg == OP_DIV) ? q_reg : acc_reg;
    assign remainder = acc_reg;

endmodule

// ----- hw/rtl/column_zscore_standardizer_core.sv -----
// Column z-score standardizer: a load leaves the input ready unless it ends a set; the final
// load of a set starts a statistics pass. A read waits on the bit-serial divide in the
// shared arithmetic unit unless it gives a raw result or an error, and may also wait on m_tready.
// Reset (aresetn low, synchronous) clears control state and the load count;
// the sample store is not cleared and needs no clearing pass.
module column_zscore_standardizer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: columns_in_use.
    input  logic                              cfg_wr_en,
    input  logic [czs_pkg::CFG_W-1:0]         cfg_wr_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [czs_pkg::SAMPLE_BITS-1:0]   s_tdata,   // [23:0] sample
    input  logic                              s_tuser,   // [0] cmd
    input  logic                              s_tlast,   // end_of_set
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [czs_pkg::VALUE_W-1:0]       m_tdata,   // [31:0] value
    output logic [czs_pkg::TUSER_W-1:0]       m_tuser,   // [0] raw_pass, [3:1] column, [4] error
    output logic                              m_tlast    // last
);
    import czs_pkg::*;

    // Sequencer and set bookkeeping.
    state_t                    state_reg, state_next;
    logic                      ready_reg, ready_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CFG_W-1:0]          cols_cfg_reg, cols_cfg_next;
    logic [CFG_W-1:0]          set_cols_reg, set_cols_next;
    logic [CNT_W-1:0]          set_total_reg, set_total_next;
    logic [ROWS_W-1:0]         rows_reg, rows_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [ROWS_W-1:0]         i_reg, i_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic signed [S1_W-1:0]    s1_reg, s1_next;
    logic [S2_W-1:0]           s2_reg, s2_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [ARITH_W-1:0]        p1_reg, p1_next;
    logic                      neg_reg, neg_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic [COL_W-1:0]          rcol_reg, rcol_next;

    // Staged result and output register.
    logic [VALUE_W-1:0]        st_value_reg, st_value_next;
    logic                      st_raw_reg, st_raw_next;
    logic [COL_W-1:0]          st_col_reg, st_col_next;
    logic                      st_last_reg, st_last_next;
    logic                      st_err_reg, st_err_next;
    logic                      m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]        m_value_reg, m_value_next;
    logic [TUSER_W-1:0]        m_user_reg, m_user_next;
    logic                      m_last_reg, m_last_next;

    // Column statistics.
    logic signed [MEAN_W-1:0]  mean_reg [MAX_COLS];
    logic [SPREAD_W-1:0]       spread_reg [MAX_COLS];
    logic                      mean_we, spread_we;
    logic signed [MEAN_W-1:0]  mean_wdata;

    // Store and arithmetic unit connections.
    logic                      st_we;
    logic [ADDR_W-1:0]         rd_addr;
    logic [SAMPLE_BITS-1:0]    mem_q;
    arith_req_t                ar_req;
    logic [ARITH_W-1:0]        ar_a, ar_b;
    logic                      ar_done;
    logic [ARITH_W-1:0]        ar_result, ar_rem;

    // Helpers.
    logic                      s_acc;
    logic [CFG_W-1:0]          cols_eff;
    logic [CNT_W-1:0]          load_limit;
    logic                      wr_ok;
    logic [CNT_W-1:0]          count_new;
    logic [ROWS_W-1:0]         rows_cap;
    logic [S1_W-1:0]           s1_mag;
    logic signed [SAMPLE_BITS-1:0] mem_x;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [MEAN_W-1:0]         mean_q;
    logic                      pos_over, neg_over;
    logic                      at_last;
    logic [COL_W-1:0]          rcol_adv;

    czs_store u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (rd_addr),
        .rdata (mem_q)
    );

    czs_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (ar_req),
        .opa       (ar_a),
        .opb       (ar_b),
        .done      (ar_done),
        .result    (ar_result),
        .remainder (ar_rem)
    );

    // Decoded helper values.
    always_comb begin
        s_acc = s_tvalid && s_tready;
        if (cols_cfg_reg == '0) begin
            cols_eff = CFG_W'(1);
        end else if (cols_cfg_reg > CFG_W'(MAX_COLS)) begin
            cols_eff = CFG_W'(MAX_COLS);
        end else begin
            cols_eff = cols_cfg_reg;
        end
        load_limit = CNT_W'(cols_eff) * CNT_W'(MAX_ROWS);
        wr_ok      = count_reg < load_limit;
        count_new  = count_reg + CNT_W'(wr_ok);
        rows_cap   = (ar_result > ARITH_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                     : ar_result[ROWS_W-1:0];
        s1_mag     = s1_reg[S1_W-1] ? S1_W'(-s1_reg) : S1_W'(s1_reg);
        mem_x      = $signed(mem_q);
        diff       = (DIFF_W'(mem_x) <<< FRAC_W) - DIFF_W'(mean_reg[rcol_reg]);
        diff_mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mean_q     = ar_result[MEAN_W-1:0];
        pos_over   = |ar_result[ARITH_W-1:VALUE_W-1];
        neg_over   = (|ar_result[ARITH_W-1:VALUE_W]) ||
                     (ar_result[VALUE_W-1] && (|ar_result[VALUE_W-2:0]));
        at_last    = (pos_reg + 1'b1) == set_total_reg;
        rcol_adv   = (CFG_W'(rcol_reg) + 1'b1 == set_cols_reg) ? '0 : rcol_reg + 1'b1;
    end

    // Sequencer: loads, statistics pass and reads.
    always_comb begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        count_next     = count_reg;
        cols_cfg_next  = cfg_wr_en ? cfg_wr_data : cols_cfg_reg;
        set_cols_next  = set_cols_reg;
        set_total_next = set_total_reg;
        rows_next      = rows_reg;
        col_next       = col_reg;
        i_next         = i_reg;
        addr_next      = addr_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        x_next         = x_reg;
        sq_next        = sq_reg;
        p1_next        = p1_reg;
        neg_next       = neg_reg;
        pos_next       = pos_reg;
        rcol_next      = rcol_reg;
        st_value_next  = st_value_reg;
        st_raw_next    = st_raw_reg;
        st_col_next    = st_col_reg;
        st_last_next   = st_last_reg;
        st_err_next    = st_err_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_value_next   = m_value_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;
        mean_we        = 1'b0;
        spread_we      = 1'b0;
        mean_wdata     = '0;
        st_we          = 1'b0;
        rd_addr        = (state_reg == ST_IDLE) ? pos_reg[ADDR_W-1:0] : addr_reg;
        ar_req.start   = 1'b0;
        ar_req.op      = OP_DIV;
        ar_a           = '0;
        ar_b           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == CMD_LOAD) begin
                        // A load always drops a finished set.
                        ready_next = 1'b0;
                        st_we      = wr_ok;
                        count_next = count_new;
                        if (s_tlast) begin
                            count_next    = '0;
                            set_cols_next = cols_eff;
                            ar_req.start  = 1'b1;
                            ar_req.op     = OP_DIV;
                            ar_a          = ARITH_W'(count_new);
                            ar_b          = ARITH_W'(cols_eff);
                            state_next    = ST_ROWS;
                        end
                    end else if (!ready_reg || pos_reg >= set_total_reg) begin
                        st_value_next = '0;
                        st_raw_next   = 1'b0;
                        st_col_next   = '0;
                        st_last_next  = 1'b0;
                        st_err_next   = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        state_next = ST_RX;
                    end
                end
            end
            ST_ROWS: begin
                if (ar_done) begin
                    if (rows_cap == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rows_next      = rows_cap;
                        set_total_next = CNT_W'(rows_cap) * CNT_W'(set_cols_reg);
                        col_next       = '0;
                        state_next     = ST_COL;
                    end
                end
            end
            ST_COL: begin
                s1_next    = '0;
                s2_next    = '0;
                i_next     = '0;
                addr_next  = ADDR_W'(col_reg);
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_SQ;
            end
            ST_SQ: begin
                x_next     = mem_x;
                sq_next    = SQ_W'(mem_x * mem_x);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                s1_next   = s1_reg + S1_W'(x_reg);
                s2_next   = s2_reg + S2_W'(sq_reg);
                i_next    = i_reg + 1'b1;
                addr_next = addr_reg + ADDR_W'(set_cols_reg);
                state_next = (ROWS_W'(i_reg + 1'b1) == rows_reg) ? ST_STAT : ST_RD;
            end
            ST_STAT: begin
                // Sum of squares times the row count.
                ar_req.start = 1'b1;
                ar_req.op    = OP_MUL;
                ar_a         = ARITH_W'(s2_reg);
                ar_b         = ARITH_W'(rows_reg);
                state_next   = ST_MULA;
            end
            ST_MULA: begin
                if (ar_done) begin
                    p1_next      = ar_result;
                    ar_req.start = 1'b1;
                    ar_req.op    = OP_MUL;
                    ar_a         = ARITH_W'(s1_mag);
                    ar_b         = ARITH_W'(s1_mag);
                    state_next   = ST_MULB;
                end
            end
            ST_MULB: begin
                // Root of the scaled variance, 32 fraction bits in, 16 out.
                if (ar_done) begin
                    ar_req.start = 1'b1;
                    ar_req.op    = OP_SQRT;
                    ar_a         = (p1_reg - ar_result) << (2 * FRAC_W);
                    state_next   = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (ar_done) begin
                    ar_req.start = 1'b1;
                    ar_req.op    = OP_DIV;
                    ar_a         = ar_result;
                    ar_b         = ARITH_W'(rows_reg);
                    state_next   = ST_SPRD;
                end
            end
            ST_SPRD: begin
                if (ar_done) begin
                    spread_we    = 1'b1;
                    ar_req.start = 1'b1;
                    ar_req.op    = OP_DIV;
                    ar_a         = ARITH_W'(s1_mag) << FRAC_W;
                    ar_b         = ARITH_W'(rows_reg);
                    state_next   = ST_MEAN;
                end
            end
            ST_MEAN: begin
                // Floor of the signed mean: round the magnitude up when negative.
                if (ar_done) begin
                    mean_we = 1'b1;
                    if (s1_reg[S1_W-1]) begin
                        mean_wdata = -$signed(mean_q + MEAN_W'(ar_rem != '0));
                    end else begin
                        mean_wdata = $signed(mean_q);
                    end
                    if (CFG_W'(col_reg) + 1'b1 == set_cols_reg) begin
                        ready_next = 1'b1;
                        pos_next   = '0;
                        rcol_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        col_next   = col_reg + 1'b1;
                        state_next = ST_COL;
                    end
                end
            end
            ST_RX: begin
                if (spread_reg[rcol_reg] == '0) begin
                    st_value_next = VALUE_W'(mem_x);
                    st_raw_next   = 1'b1;
                    st_col_next   = rcol_reg;
                    st_last_next  = at_last;
                    st_err_next   = 1'b0;
                    pos_next      = pos_reg + 1'b1;
                    rcol_next     = rcol_adv;
                    state_next    = ST_OUT;
                end else begin
                    neg_next     = diff[DIFF_W-1];
                    ar_req.start = 1'b1;
                    ar_req.op    = OP_DIV;
                    ar_a         = ARITH_W'(diff_mag) << FRAC_W;
                    ar_b         = ARITH_W'(spread_reg[rcol_reg]);
                    state_next   = ST_RDIV;
                end
            end
            ST_RDIV: begin
                // Saturate the quotient magnitude to the signed result range.
                if (ar_done) begin
                    if (!neg_reg) begin
                        st_value_next = pos_over ? {1'b0, {(VALUE_W-1){1'b1}}}
                                                 : ar_result[VALUE_W-1:0];
                    end else begin
                        st_value_next = neg_over ? {1'b1, {(VALUE_W-1){1'b0}}}
                                                 : VALUE_W'(-ar_result[VALUE_W-1:0]);
                    end
                    st_raw_next  = 1'b0;
                    st_col_next  = rcol_reg;
                    st_last_next = at_last;
                    st_err_next  = 1'b0;
                    pos_next     = pos_reg + 1'b1;
                    rcol_next    = rcol_adv;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_value_next = st_value_reg;
                    m_user_next  = {st_err_reg, st_col_reg, st_raw_reg};
                    m_last_next  = st_last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            count_reg     <= '0;
            cols_cfg_reg  <= CFG_W'(MAX_COLS);
            set_cols_reg  <= CFG_W'(1);
            set_total_reg <= '0;
            pos_reg       <= '0;
            rcol_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            count_reg     <= count_next;
            cols_cfg_reg  <= cols_cfg_next;
            set_cols_reg  <= set_cols_next;
            set_total_reg <= set_total_next;
            pos_reg       <= pos_next;
            rcol_reg      <= rcol_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rows_reg     <= rows_next;
        col_reg      <= col_next;
        i_reg        <= i_next;
        addr_reg     <= addr_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        x_reg        <= x_next;
        sq_reg       <= sq_next;
        p1_reg       <= p1_next;
        neg_reg      <= neg_next;
        st_value_reg <= st_value_next;
        st_raw_reg   <= st_raw_next;
        st_col_reg   <= st_col_next;
        st_last_reg  <= st_last_next;
        st_err_reg   <= st_err_next;
        m_value_reg  <= m_value_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    // Per-column mean and spread.
    always_ff @(posedge aclk) begin
        if (mean_we) begin
            mean_reg[col_reg] <= mean_wdata;
        end
        if (spread_we) begin
            spread_reg[col_reg] <= ar_result[SPREAD_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- tb/column_zscore_standardizer_core_tb.sv -----
// Testbench for column_zscore_standardizer_core: drives loads and reads on the
// input stream and checks each result against a built-in z-score predictor.
// Depends on czs_pkg and the core RTL only.
`timescale 1ns / 1ps

module column_zscore_standardizer_core_tb;
    import czs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [23:0] S_MAX = 24'h7FFFFF;
    localparam logic [23:0] S_MIN = 24'h800000;

    // One result of the block.
    typedef struct packed {
        logic [31:0] value;
        logic        raw;
        logic [2:0]  col;
        logic        last;
        logic        err;
    } zres_t;

    // One row of the directed stimulus table.
    typedef struct {
        logic        cmd;
        logic [23:0] smp;
        logic        eos;
        bit          typed;
        zres_t       want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [23:0] sample
    logic        s_tuser = 1'b0; // [0] cmd
    logic        s_tlast = 1'b0; // end_of_set
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] value
    logic [4:0]  m_tuser;        // [0] raw_pass, [3:1] column, [4] error
    logic        m_tlast;        // last

    column_zscore_standardizer_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Predictor state: its own copy of the table, statistics and register.
    logic [23:0]  tbl[STORE_DEPTH];
    int unsigned  n_loaded = 0;
    bit           set_ready = 1'b0;
    int unsigned  lat_cols = 1;
    int unsigned  lat_total = 0;
    int unsigned  rd_pos = 0;
    longint       col_mean[MAX_COLS];
    logic [63:0]  col_spread[MAX_COLS];
    logic [3:0]   cols_reg = 4'd8;
    int unsigned  pass_cycles = 0;

    zres_t        zscore_q[$];
    int unsigned  n_items = 0;
    int unsigned  n_sets = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_fail = 0;
    int unsigned  cycles = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    bit           stall_on = 1'b0;
    event         hold_ev;

    dir_row_t     dir_tab[$];

    function automatic int unsigned eff_cols(input logic [3:0] c);
        if (c == 0) return 1;
        if (c > MAX_COLS) return MAX_COLS;
        return c;
    endfunction

    function automatic logic [63:0] floor_sqrt128(input logic [127:0] v);
        logic [127:0] root, bitv, t;
        root = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0) begin
            t = root + bitv;
            if (v >= t) begin
                v = v - t;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[63:0];
    endfunction

    // Statistics pass at the end of a set: floor mean and floor spread in Q16.
    function automatic void stats_pass();
        int unsigned  c, rows, i, j;
        longint       s1, q, r, x;
        logic [127:0] s2, d, a;
        logic [63:0]  ax;
        c = eff_cols(cols_reg);
        rows = n_loaded / c;
        n_loaded = 0;
        pass_cycles = 150 + c * (3 * rows + 420);
        if (rows == 0) begin
            set_ready = 1'b0;
            return;
        end
        lat_cols = c;
        lat_total = rows * c;
        for (j = 0; j < c; j++) begin
            s1 = 0;
            s2 = '0;
            for (i = 0; i < rows; i++) begin
                x = longint'($signed(tbl[i * c + j]));
                ax = (x < 0) ? -x : x;
                s1 += x;
                s2 = s2 + 128'(ax) * 128'(ax);
            end
            q = s1 / longint'(rows);
            r = s1 % longint'(rows);
            if (r < 0) begin
                q -= 1;
                r += longint'(rows);
            end
            col_mean[j] = q * 65536 + (r * 65536) / longint'(rows);
            a = 128'(s1 < 0 ? -s1 : s1);
            d = s2 * 128'(rows) - a * a;
            d = d << 32;
            col_spread[j] = floor_sqrt128(d) / 64'(rows);
        end
        rd_pos = 0;
        set_ready = 1'b1;
    endfunction

    function automatic void load_sample(input logic [23:0] smp, input logic eos);
        int unsigned c;
        c = eff_cols(cols_reg);
        if (set_ready) begin
            set_ready = 1'b0;
            n_loaded = 0;
        end
        if (n_loaded < MAX_ROWS * c) begin
            tbl[n_loaded] = smp;
            n_loaded++;
        end
        if (eos) stats_pass();
    endfunction

    // Next normalized value, or an error result when none is available.
    function automatic zres_t read_zscore();
        zres_t        o;
        int unsigned  pos, col;
        longint       x, diff;
        logic [63:0]  mag, sp;
        logic [127:0] qt;
        o = '0;
        if (!set_ready || rd_pos >= lat_total) begin
            o.err = 1'b1;
            return o;
        end
        pos = rd_pos;
        col = pos % lat_cols;
        x = longint'($signed(tbl[pos]));
        sp = col_spread[col];
        if (sp == 0) begin
            o.value = x[31:0];
            o.raw = 1'b1;
        end else begin
            diff = x * 65536 - col_mean[col];
            mag = (diff < 0) ? -diff : diff;
            qt = (128'(mag) << 16) / 128'(sp);
            if (diff >= 0)
                o.value = (qt > 128'h7FFFFFFF) ? 32'h7FFFFFFF : qt[31:0];
            else
                o.value = (qt > 128'h80000000) ? 32'h80000000 : -qt[31:0];
        end
        o.col = col[2:0];
        o.last = (pos + 1 == lat_total);
        rd_pos = pos + 1;
        return o;
    endfunction

    // Offer one transaction, wait for acceptance, then update the prediction.
    task automatic push_item(input logic cmd, input logic [23:0] smp, input logic eos,
                             input bit typed, input zres_t want);
        zres_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= smp;
        s_tlast <= eos;
        do @(posedge aclk); while (!s_tready);
        n_items++;
        if (cmd == CMD_READ) begin
            r = read_zscore();
            if (typed) r = want;
            zscore_q = {zscore_q, r};
        end else begin
            load_sample(smp, eos);
        end
    endtask

    // Register write once the block has drained and any pass has finished.
    task automatic write_cols(input logic [3:0] v);
        s_tvalid <= 1'b0;
        while (zscore_q.size() != 0) @(posedge aclk);
        repeat (pass_cycles) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cols_reg = v;
    endtask

    // One random data set followed by reads of its results; on request the
    // receiver holds off once the first read is in.
    task automatic run_set(input int unsigned rows, input bit partial, input bit hold);
        int unsigned c, n, i, j, nreads;
        int unsigned mode[MAX_COLS];
        logic [23:0] base[MAX_COLS];
        logic [23:0] v;
        c = eff_cols(cols_reg);
        for (j = 0; j < c; j++) begin
            mode[j] = $urandom_range(3);
            base[j] = 24'($urandom);
        end
        // A stray read now and then, before the set is loaded.
        if ($urandom_range(5) == 0)
            push_item(CMD_READ, 24'($urandom), 1'($urandom), 1'b0, '0);
        n = rows * c + ((partial && c > 1) ? $urandom_range(1, c - 1) : 0);
        for (i = 0; i < n; i++) begin
            j = i % c;
            case (mode[j])
                0: v = 24'($urandom);
                1: v = base[j] + 24'($urandom_range(15));
                2: v = base[j];
                default: v = $urandom_range(1) ? S_MAX : S_MIN;
            endcase
            push_item(CMD_LOAD, v, i == n - 1, 1'b0, '0);
        end
        n_sets++;
        nreads = rows * c;
        case ($urandom_range(4))
            0: nreads = nreads + 1;
            1: nreads = nreads / 2;
            default: ;
        endcase
        for (i = 0; i < nreads; i++) begin
            push_item(CMD_READ, 24'($urandom), 1'($urandom), 1'b0, '0);
            if (hold && i == 0) -> hold_ev;
        end
    endtask

    // Result side: random ready, with a long hold-off on request.
    always @(posedge aclk) begin
        m_tready <= !stall_on && ($urandom_range(99) >= recv_idle_pct);
    end

    always begin
        @(hold_ev);
        stall_on = 1'b1;
        repeat (400) @(posedge aclk);
        stall_on = 1'b0;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        zres_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (zscore_q.size() == 0) begin
                $error("unexpected result transaction: value %h user %h", m_tdata, m_tuser);
                n_fail++;
            end else begin
                e = zscore_q.pop_front();
                n_checked++;
                if (m_tdata !== e.value) begin
                    $error("value: expected %h, got %h", e.value, m_tdata);
                    n_fail++;
                end
                if (m_tuser[0] !== e.raw) begin
                    $error("raw_pass: expected %b, got %b", e.raw, m_tuser[0]);
                    n_fail++;
                end
                if (m_tuser[3:1] !== e.col) begin
                    $error("column: expected %0d, got %0d", e.col, m_tuser[3:1]);
                    n_fail++;
                end
                if (m_tuser[4] !== e.err) begin
                    $error("error: expected %b, got %b", e.err, m_tuser[4]);
                    n_fail++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %b, got %b", e.last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("column_zscore_standardizer_core_tb NOT OK");
            $finish;
        end
    end

    function automatic void add_row(input logic cmd, input logic [23:0] smp, input logic eos,
                                    input bit typed, input zres_t want);
        dir_row_t d;
        d.cmd = cmd;
        d.smp = smp;
        d.eos = eos;
        d.typed = typed;
        d.want = want;
        dir_tab = {dir_tab, d};
    endfunction

    // Main stimulus.
    initial begin
        zres_t err_res, raw_res;
        logic [3:0] cfg_seq[8];
        int unsigned k, ph, start, i;
        cfg_seq = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2};
        err_res = '0;
        err_res.err = 1'b1;
        raw_res = '0;
        raw_res.value = 32'd5;
        raw_res.raw = 1'b1;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: read with no set, extremes in two columns with a partial
        // row, read past the end, a zero-spread set, and an empty set.
        add_row(CMD_READ, '0, 1'b0, 1'b1, err_res);
        add_row(CMD_LOAD, S_MAX, 1'b0, 1'b0, '0);
        add_row(CMD_LOAD, S_MIN, 1'b0, 1'b0, '0);
        add_row(CMD_LOAD, S_MAX, 1'b0, 1'b0, '0);
        add_row(CMD_LOAD, S_MIN, 1'b0, 1'b0, '0);
        add_row(CMD_LOAD, S_MIN, 1'b0, 1'b0, '0);
        add_row(CMD_LOAD, 24'd5, 1'b0, 1'b0, '0);
        add_row(CMD_LOAD, 24'd123, 1'b1, 1'b0, '0);
        for (i = 0; i < 6; i++) add_row(CMD_READ, '0, 1'b0, 1'b0, '0);
        add_row(CMD_READ, '1, 1'b1, 1'b1, err_res);
        for (i = 0; i < 4; i++) add_row(CMD_LOAD, 24'd5, i == 3, 1'b0, '0);
        for (i = 0; i < 4; i++) begin
            raw_res.col = 3'(i % 2);
            raw_res.last = (i == 3);
            add_row(CMD_READ, '0, 1'b0, 1'b1, raw_res);
        end
        add_row(CMD_LOAD, 24'd77, 1'b1, 1'b0, '0);
        add_row(CMD_READ, '0, 1'b0, 1'b1, err_res);

        send_idle_pct = 11;
        recv_idle_pct = 77;
        write_cols(4'd2);
        foreach (dir_tab[r])
            push_item(dir_tab[r].cmd, dir_tab[r].smp, dir_tab[r].eos,
                      dir_tab[r].typed, dir_tab[r].want);

        // Random sets in three idling regimes.
        k = 0;
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 11 : 0;
            start = n_items;
            while (n_items - start < 110) begin
                write_cols(cfg_seq[k % 8]);
                k++;
                run_set($urandom_range(1, 6), $urandom_range(2) == 0,
                        ph == 2 && k % 3 == 0);
            end
        end

        s_tvalid <= 1'b0;
        while (zscore_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Covered %0d transactions over %0d data sets at varied column counts,",
                 n_items, n_sets);
        $display("%0d results compared, %0d mismatches.", n_checked, n_fail);
        if (n_fail == 0) begin
            $display("column_zscore_standardizer_core_tb OK");
        end else begin
            $display("column_zscore_standardizer_core_tb NOT OK");
        end
        $finish;
    end

endmodule
